// ===== rtl/core/psd_pkg.sv =====
// Package: shared constants and types for the port scan detector
`timescale 1ns / 1ps
package psd_pkg;
    localparam int TABLE_ENTRIES_DEF   = 64;
    localparam int PORTS_PER_ENTRY_DEF = 30;

    localparam logic [15:0] WINDOW_RST  = 16'd10;
    localparam logic [4:0]  THRESH_RST  = 5'd15;
    localparam logic [15:0] HOLD_RST    = 16'd3;
    localparam logic [15:0] STALE_RST   = 16'd60;
    localparam logic [15:0] CLEANUP_RST = 16'd1000;

    localparam logic [2:0] REG_WINDOW  = 3'd0;
    localparam logic [2:0] REG_THRESH  = 3'd1;
    localparam logic [2:0] REG_HOLD    = 3'd2;
    localparam logic [2:0] REG_STALE   = 3'd3;
    localparam logic [2:0] REG_CLEANUP = 3'd4;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SWEEP = 10'b0000000010,
        ST_SWCHK = 10'b0000000100,
        ST_SCAN  = 10'b0000001000,
        ST_SCCHK = 10'b0000010000,
        ST_DECIDE= 10'b0000100000,
        ST_PORT  = 10'b0001000000,
        ST_PCHK  = 10'b0010000000,
        ST_APPLY = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;
endpackage

// ===== rtl/core/psd_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read
`timescale 1ns / 1ps
module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/port_scan_detector_core.sv =====
// Top level: port scan detector with slot table and port memory
`timescale 1ns / 1ps
// Usage: pulse start with source_address, destination_port and now_seconds
// while busy is low; the event is taken at that edge and busy rises.
// One result comes back on alert_raised, entry_started, dropped_full and
// ports_seen with done high for exactly one cycle; the receiver cannot stall.
// Each event walks the slot table; a new, dropped or window-restarted source
// then finishes, else the stored ports of the matched slot are compared
// (the compare stops at a hit); a sweep event first walks the table once more.
// The slot table memory is walked one slot at a time (registered read,
// then one shared address/age compare), and the port list of the matched
// slot is walked the same way. Busy stays high throughout and drops in the
// cycle that done is high, so the next event can be taken at the edge that
// takes the result.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while busy is low. Reset clears the valid bits, the sweep
// counter and restores register defaults; no clearing pass is needed.
module port_scan_detector_core #(
    parameter int TABLE_ENTRIES   = psd_pkg::TABLE_ENTRIES_DEF,
    parameter int PORTS_PER_ENTRY = psd_pkg::PORTS_PER_ENTRY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_address,
    input  logic [15:0] destination_port,
    input  logic [31:0] now_seconds,
    output logic        done,
    output logic        alert_raised,
    output logic        entry_started,
    output logic        dropped_full,
    output logic [4:0]  ports_seen,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(PORTS_PER_ENTRY + 1);
    localparam int MD = TABLE_ENTRIES * PORTS_PER_ENTRY;
    localparam int MW = $clog2(MD);
    localparam int EW = 32 + 32 + 32 + 1 + CW;
    localparam logic [SW:0] NSLOT = (SW+1)'(TABLE_ENTRIES);
    localparam logic [CW-1:0] PMAX = CW'(PORTS_PER_ENTRY);

    logic [15:0] window_reg, hold_reg, stale_reg, cleanup_reg, ev_reg;
    logic [4:0]  thresh_reg;
    psd_pkg::state_t state_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0] addr_reg, now_reg;
    logic [15:0] port_reg;
    logic [SW:0] idx_reg;
    logic [CW-1:0] pidx_reg;
    logic        found_reg, free_ok_reg, present_reg;
    logic [SW-1:0] found_slot_reg, free_slot_reg;
    logic [EW-1:0] ent_reg;

    // slot entry memory: address, first time, alert time, alerted, count
    logic          e_we;
    logic [SW-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic          p_we;
    logic [MW-1:0] p_waddr, p_raddr;
    logic [15:0]   p_wdata, p_rdata;

    psd_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ent (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    psd_ram #(.WIDTH(16), .DEPTH(MD)) u_port (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic [31:0]   r_addr, r_first;
    assign r_addr  = e_rdata[EW-1 -: 32];
    assign r_first = e_rdata[EW-33 -: 32];

    logic [31:0]   c_first, c_atime;
    logic          c_alerted;
    logic [CW-1:0] c_count;
    assign c_first   = ent_reg[EW-33 -: 32];
    assign c_atime   = ent_reg[EW-65 -: 32];
    assign c_alerted = ent_reg[CW];
    assign c_count   = ent_reg[CW-1:0];

    // shared age subtractor
    logic [31:0] age_base, age;
    always_comb
    begin
        case (state_reg)
            psd_pkg::ST_SWCHK: age_base = r_first;
            psd_pkg::ST_APPLY: age_base = c_atime;
            default:           age_base = c_first;
        endcase
    end
    assign age = now_reg - age_base;

    logic [15:0] ev_inc;
    assign ev_inc = ev_reg + 16'd1;

    logic [SW-1:0] cur_slot;
    assign cur_slot = idx_reg[SW-1:0];
    assign e_raddr  = cur_slot;
    assign p_raddr  = MW'(found_slot_reg * PORTS_PER_ENTRY + pidx_reg);

    // apply decision
    logic restart, append, do_alert;
    always_comb
    begin
        restart  = 1'b0;
        append   = 1'b0;
        do_alert = 1'b0;
        if (!present_reg)
        begin
            if ({{(8-CW){1'b0}}, c_count} >= {3'b0, thresh_reg} || CW > 8)
            begin
                if (!c_alerted)
                begin
                    do_alert = 1'b1;
                    append   = 1'b1;
                end
                else if (age < {16'd0, hold_reg})
                    append = 1'b1;
                else
                    restart = 1'b1;
            end
            else
                append = 1'b1;
        end
    end
    logic          can_app;
    logic [CW-1:0] new_count;
    assign can_app   = append && (c_count < PMAX);
    assign new_count = can_app ? c_count + CW'(1) : c_count;

    logic [CW-1:0] one_c;
    assign one_c = CW'(1);

    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = found_slot_reg;
        e_wdata = {addr_reg, now_reg, 32'd0, 1'b0, one_c};
        p_we    = 1'b0;
        p_waddr = MW'(found_slot_reg * PORTS_PER_ENTRY);
        p_wdata = port_reg;
        if (state_reg == psd_pkg::ST_DECIDE)
        begin
            if (!found_reg && free_ok_reg)
            begin
                e_we    = 1'b1;
                e_waddr = free_slot_reg;
                p_we    = 1'b1;
                p_waddr = MW'(free_slot_reg * PORTS_PER_ENTRY);
            end
            else if (found_reg && age > {16'd0, window_reg})
            begin
                e_we = 1'b1;
                p_we = 1'b1;
            end
        end
        else if (state_reg == psd_pkg::ST_APPLY)
        begin
            if (restart)
            begin
                e_we = 1'b1;
                p_we = 1'b1;
            end
            else if (do_alert || can_app)
            begin
                e_we    = 1'b1;
                e_wdata = {addr_reg, c_first, do_alert ? now_reg : c_atime,
                           c_alerted | do_alert, new_count};
                p_we    = can_app;
                p_waddr = MW'(found_slot_reg * PORTS_PER_ENTRY + c_count);
            end
        end
    end

    assign busy = (state_reg != psd_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= psd_pkg::WINDOW_RST;
            thresh_reg  <= psd_pkg::THRESH_RST;
            hold_reg    <= psd_pkg::HOLD_RST;
            stale_reg   <= psd_pkg::STALE_RST;
            cleanup_reg <= psd_pkg::CLEANUP_RST;
            ev_reg      <= 16'd0;
            state_reg   <= psd_pkg::ST_IDLE;
            valid_reg   <= '0;
            done        <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    psd_pkg::REG_WINDOW:  window_reg  <= cfg_data;
                    psd_pkg::REG_THRESH:  thresh_reg  <= cfg_data[4:0];
                    psd_pkg::REG_HOLD:    hold_reg    <= cfg_data;
                    psd_pkg::REG_STALE:   stale_reg   <= cfg_data;
                    psd_pkg::REG_CLEANUP: cleanup_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                psd_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        addr_reg    <= source_address;
                        port_reg    <= destination_port;
                        now_reg     <= now_seconds;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        if (ev_inc >= cleanup_reg)
                        begin
                            ev_reg    <= 16'd0;
                            state_reg <= psd_pkg::ST_SWEEP;
                        end
                        else
                        begin
                            ev_reg    <= ev_inc;
                            state_reg <= psd_pkg::ST_SCAN;
                        end
                    end
                end
                psd_pkg::ST_SWEEP: state_reg <= psd_pkg::ST_SWCHK;
                psd_pkg::ST_SWCHK:
                begin
                    if (age > {16'd0, stale_reg})
                        valid_reg[cur_slot] <= 1'b0;
                    if (idx_reg == NSLOT - 1'b1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= psd_pkg::ST_SCAN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= psd_pkg::ST_SWEEP;
                    end
                end
                psd_pkg::ST_SCAN: state_reg <= psd_pkg::ST_SCCHK;
                psd_pkg::ST_SCCHK:
                begin
                    if (valid_reg[cur_slot])
                    begin
                        if (!found_reg && r_addr == addr_reg)
                        begin
                            found_reg      <= 1'b1;
                            found_slot_reg <= cur_slot;
                            ent_reg        <= e_rdata;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_reg   <= 1'b1;
                        free_slot_reg <= cur_slot;
                    end
                    if (idx_reg == NSLOT - 1'b1)
                        state_reg <= psd_pkg::ST_DECIDE;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= psd_pkg::ST_SCAN;
                    end
                end
                psd_pkg::ST_DECIDE:
                begin
                    alert_raised <= 1'b0;
                    entry_started <= 1'b0;
                    dropped_full <= 1'b0;
                    pidx_reg    <= '0;
                    present_reg <= 1'b0;
                    if (!found_reg)
                    begin
                        if (free_ok_reg)
                        begin
                            valid_reg[free_slot_reg] <= 1'b1;
                            entry_started <= 1'b1;
                            ports_seen    <= 5'd1;
                        end
                        else
                        begin
                            dropped_full <= 1'b1;
                            ports_seen   <= 5'd0;
                        end
                        state_reg <= psd_pkg::ST_DONE;
                    end
                    else if (age > {16'd0, window_reg})
                    begin
                        entry_started <= 1'b1;
                        ports_seen    <= 5'd1;
                        state_reg     <= psd_pkg::ST_DONE;
                    end
                    else if (c_count == '0)
                        state_reg <= psd_pkg::ST_APPLY;
                    else
                        state_reg <= psd_pkg::ST_PORT;
                end
                psd_pkg::ST_PORT: state_reg <= psd_pkg::ST_PCHK;
                psd_pkg::ST_PCHK:
                begin
                    // stop at the first hit or at the end of the list
                    if (p_rdata == port_reg)
                    begin
                        present_reg <= 1'b1;
                        state_reg   <= psd_pkg::ST_APPLY;
                    end
                    else if (pidx_reg + 1'b1 >= c_count || pidx_reg + 1'b1 >= PMAX)
                        state_reg <= psd_pkg::ST_APPLY;
                    else
                    begin
                        pidx_reg  <= pidx_reg + 1'b1;
                        state_reg <= psd_pkg::ST_PORT;
                    end
                end
                psd_pkg::ST_APPLY:
                begin
                    alert_raised  <= do_alert;
                    entry_started <= restart;
                    ports_seen    <= restart ? 5'd1 : 5'(new_count);
                    state_reg     <= psd_pkg::ST_DONE;
                end
                psd_pkg::ST_DONE:
                begin
                    done      <= 1'b1;
                    state_reg <= psd_pkg::ST_IDLE;
                end
                default: state_reg <= psd_pkg::ST_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == psd_pkg::ST_DONE)) else $error("stray done");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(dropped_full && (entry_started || alert_raised)))
        else $error("conflicting flags");
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped_full) |-> ports_seen == 5'd0) else $error("drop count");
endmodule
